// ===== sv/qau_pkg.sv =====
// shared types, constants and operation codes of the quaternion arithmetic unit
package qau_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int COMP_WIDTH   = 16;
	localparam int SCALAR_WIDTH = 2 * COMP_WIDTH - FRAC_BITS + 2;

	// multiplier operands carry one extra bit for the lerp difference b - a
	localparam int OPND_WIDTH = COMP_WIDTH + 1;
	localparam int PROD_WIDTH = 2 * OPND_WIDTH;
	localparam int RND_WIDTH  = PROD_WIDTH - FRAC_BITS;
	localparam int SUM_WIDTH  = RND_WIDTH + 2;
	localparam int NUM_COMP   = 4;
	localparam int NUM_PROD   = NUM_COMP * NUM_COMP;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	// component positions inside a quaternion
	localparam int QI = 0;
	localparam int QJ = 1;
	localparam int QK = 2;
	localparam int QW = 3;

	localparam logic [PROD_WIDTH-1:0] HALF_LSB = PROD_WIDTH'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_WIDTH-1:0] DOT_LIM =
		SUM_WIDTH'((64'sd1 <<< FRAC_BITS) - 64'sd1);
	localparam logic signed [SUM_WIDTH-1:0] COMP_MAX =
		SUM_WIDTH'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_WIDTH-1:0] COMP_MIN = -COMP_MAX - SUM_WIDTH'(1);

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef comp_t [NUM_COMP-1:0] quat_t;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_MUL   = 3'd1,
		OP_CONJ  = 3'd2,
		OP_SCALE = 3'd3,
		OP_LERP  = 3'd4,
		OP_NORM  = 3'd5,
		OP_DOT   = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_QUAT,
		KIND_SCALAR
	} kind_t;

	typedef struct packed {
		op_t   op;
		kind_t kind;
		quat_t a;
		quat_t b;
		comp_t t;
	} item_t;

endpackage

// ===== sv/qau_front.sv =====
// front end: takes requests, classifies the opcode and packs the queue entry
module qau_front import qau_pkg::*; (
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] req_type,
	input  comp_t      a_i,
	input  comp_t      a_j,
	input  comp_t      a_k,
	input  comp_t      a_w,
	input  comp_t      b_i,
	input  comp_t      b_j,
	input  comp_t      b_k,
	input  comp_t      b_w,
	input  comp_t      factor,
	input  logic       q_full,
	output logic       push,
	output item_t      item
);

	op_t   op;
	kind_t kind;

	assign op = op_t'(req_type);

	always_comb begin
		unique case (op) inside
			OP_ADD, OP_MUL, OP_CONJ, OP_SCALE, OP_LERP: kind = KIND_QUAT;
			OP_NORM, OP_DOT:                            kind = KIND_SCALAR;
			default:                                    kind = KIND_NONE;
		endcase
	end

	assign req_ready = !q_full;
	assign push      = req_valid && !q_full;

	assign item.op   = op;
	assign item.kind = kind;
	assign item.a    = {a_w, a_k, a_j, a_i};
	assign item.b    = {b_w, b_k, b_j, b_i};
	assign item.t    = factor;

endmodule

// ===== sv/qau_queue.sv =====
// short queue between front end and execution pipeline
module qau_queue import qau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	input  logic  pop,
	output logic  full,
	output logic  q_valid,
	output item_t rd_item
);

	item_t                 entries_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_ptr_q;
	logic [QPTR_WIDTH-1:0] rd_ptr_q;
	logic [QCNT_WIDTH-1:0] count_q;

	function automatic logic [QPTR_WIDTH-1:0] next_ptr(input logic [QPTR_WIDTH-1:0] p);
		if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1))
			return '0;
		return p + QPTR_WIDTH'(1);
	endfunction

	assign full    = (count_q == QCNT_WIDTH'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign rd_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + QCNT_WIDTH'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_WIDTH'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !pop)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_WIDTH'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== sv/qau_back.sv =====
// execution pipeline: operand select, rounded products, sums with saturation
module qau_back import qau_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  item_t                          q_item,
	output logic                           pop,
	output logic                           res_valid,
	input  logic                           res_ready,
	output comp_t                          r_i,
	output comp_t                          r_j,
	output comp_t                          r_k,
	output comp_t                          r_w,
	output logic signed [SCALAR_WIDTH-1:0] scalar,
	output logic                           saturated
);

	logic en;

	// stage 1: multiplier operands
	logic signed [OPND_WIDTH-1:0] mx_d  [NUM_PROD];
	logic signed [OPND_WIDTH-1:0] my_d  [NUM_PROD];
	logic signed [OPND_WIDTH-1:0] mx_s1 [NUM_PROD];
	logic signed [OPND_WIDTH-1:0] my_s1 [NUM_PROD];
	op_t   op_s1;
	kind_t kind_s1;
	quat_t a_s1;
	quat_t b_s1;
	logic  v_s1;

	// stage 2: rounded products
	logic signed [PROD_WIDTH-1:0] mult  [NUM_PROD];
	logic        [PROD_WIDTH-1:0] rnd   [NUM_PROD];
	logic signed [RND_WIDTH-1:0]  p_s2  [NUM_PROD];
	op_t   op_s2;
	kind_t kind_s2;
	quat_t a_s2;
	quat_t b_s2;
	logic  v_s2;

	// stage 3: output register
	logic signed [SUM_WIDTH-1:0] pe [NUM_PROD];
	logic signed [SUM_WIDTH-1:0] ae [NUM_COMP];
	logic signed [SUM_WIDTH-1:0] be [NUM_COMP];
	logic signed [SUM_WIDTH-1:0] s  [NUM_COMP];
	logic signed [SUM_WIDTH-1:0] sc;
	quat_t                          r_d;
	logic                           sat_d;
	quat_t                          r_s3;
	logic signed [SCALAR_WIDTH-1:0] scalar_s3;
	logic                           sat_s3;
	op_t                            op_s3;
	kind_t                          kind_s3;
	logic                           v_s3;

	// the whole pipeline holds while a finished result waits
	assign en        = !v_s3 || res_ready;
	assign pop       = en && q_valid;
	assign res_valid = v_s3;

	// products are laid out as p[x][y] = a_x * b_y; single-product ops use the diagonal
	always_comb begin
		for (int n = 0; n < NUM_PROD; n++) begin
			mx_d[n] = '0;
			my_d[n] = '0;
		end
		case (q_item.op)
			OP_MUL: begin
				for (int n = 0; n < NUM_PROD; n++) begin
					mx_d[n] = OPND_WIDTH'(q_item.a[n / NUM_COMP]);
					my_d[n] = OPND_WIDTH'(q_item.b[n % NUM_COMP]);
				end
			end
			OP_SCALE: begin
				for (int x = 0; x < NUM_COMP; x++) begin
					mx_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.t);
					my_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.a[x]);
				end
			end
			OP_LERP: begin
				for (int x = 0; x < NUM_COMP; x++) begin
					mx_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.t);
					my_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.b[x])
						- OPND_WIDTH'(q_item.a[x]);
				end
			end
			OP_NORM: begin
				for (int x = 0; x < NUM_COMP; x++) begin
					mx_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.a[x]);
					my_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.a[x]);
				end
			end
			OP_DOT: begin
				for (int x = 0; x < NUM_COMP; x++) begin
					mx_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.a[x]);
					my_d[x * (NUM_COMP + 1)] = OPND_WIDTH'(q_item.b[x]);
				end
			end
			default: begin
			end
		endcase
	end

	// round to nearest: add half an lsb, keep the bits above the fraction
	always_comb begin
		for (int n = 0; n < NUM_PROD; n++) begin
			mult[n] = PROD_WIDTH'(mx_s1[n]) * PROD_WIDTH'(my_s1[n]);
			rnd[n]  = mult[n] + HALF_LSB;
		end
	end

	always_comb begin
		for (int n = 0; n < NUM_PROD; n++)
			pe[n] = SUM_WIDTH'(p_s2[n]);
		for (int x = 0; x < NUM_COMP; x++) begin
			ae[x] = SUM_WIDTH'(a_s2[x]);
			be[x] = SUM_WIDTH'(b_s2[x]);
		end
	end

	always_comb begin
		for (int x = 0; x < NUM_COMP; x++)
			s[x] = '0;
		sc = '0;
		case (op_s2)
			OP_ADD: begin
				for (int x = 0; x < NUM_COMP; x++)
					s[x] = ae[x] + be[x];
			end
			OP_MUL: begin
				s[QI] = pe[QJ*NUM_COMP+QK] - pe[QK*NUM_COMP+QJ]
					+ pe[QW*NUM_COMP+QI] + pe[QI*NUM_COMP+QW];
				s[QJ] = pe[QK*NUM_COMP+QI] - pe[QI*NUM_COMP+QK]
					+ pe[QW*NUM_COMP+QJ] + pe[QJ*NUM_COMP+QW];
				s[QK] = pe[QI*NUM_COMP+QJ] - pe[QJ*NUM_COMP+QI]
					+ pe[QW*NUM_COMP+QK] + pe[QK*NUM_COMP+QW];
				s[QW] = pe[QW*NUM_COMP+QW] - pe[QI*NUM_COMP+QI]
					- pe[QJ*NUM_COMP+QJ] - pe[QK*NUM_COMP+QK];
			end
			OP_CONJ: begin
				s[QI] = -ae[QI];
				s[QJ] = -ae[QJ];
				s[QK] = -ae[QK];
				s[QW] = ae[QW];
			end
			OP_SCALE: begin
				for (int x = 0; x < NUM_COMP; x++)
					s[x] = pe[x * (NUM_COMP + 1)];
			end
			OP_LERP: begin
				for (int x = 0; x < NUM_COMP; x++)
					s[x] = ae[x] + pe[x * (NUM_COMP + 1)];
			end
			OP_NORM: begin
				for (int x = 0; x < NUM_COMP; x++)
					sc = sc + pe[x * (NUM_COMP + 1)];
			end
			OP_DOT: begin
				for (int x = 0; x < NUM_COMP; x++)
					sc = sc + pe[x * (NUM_COMP + 1)];
				if (sc > DOT_LIM)
					sc = DOT_LIM;
				else if (sc < -DOT_LIM)
					sc = -DOT_LIM;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sat_d = 1'b0;
		for (int x = 0; x < NUM_COMP; x++) begin
			if (s[x] > COMP_MAX) begin
				r_d[x] = COMP_WIDTH'(COMP_MAX);
				sat_d  = 1'b1;
			end else if (s[x] < COMP_MIN) begin
				r_d[x] = COMP_WIDTH'(COMP_MIN);
				sat_d  = 1'b1;
			end else begin
				r_d[x] = COMP_WIDTH'(s[x]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < NUM_PROD; n++) begin
				mx_s1[n] <= mx_d[n];
				my_s1[n] <= my_d[n];
				p_s2[n]  <= rnd[n][PROD_WIDTH-1:FRAC_BITS];
			end
			op_s1     <= q_item.op;
			kind_s1   <= q_item.kind;
			a_s1      <= q_item.a;
			b_s1      <= q_item.b;
			op_s2     <= op_s1;
			kind_s2   <= kind_s1;
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			r_s3      <= r_d;
			scalar_s3 <= SCALAR_WIDTH'(sc);
			sat_s3    <= sat_d;
			op_s3     <= op_s2;
			kind_s3   <= kind_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign r_i       = r_s3[QI];
	assign r_j       = r_s3[QJ];
	assign r_k       = r_s3[QK];
	assign r_w       = r_s3[QW];
	assign scalar    = scalar_s3;
	assign saturated = sat_s3;

`ifndef NO_ASSERTIONS
	a_scalar_op_clean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && kind_s3 == KIND_SCALAR |-> r_s3 == '0 && !sat_s3)
		else $error("scalar result with non-zero components or flag");
	a_quat_op_clean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && kind_s3 != KIND_SCALAR |-> scalar_s3 == '0)
		else $error("quaternion result with non-zero scalar");
	a_dot_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && op_s3 == OP_DOT |->
			scalar_s3 <= SCALAR_WIDTH'(DOT_LIM) && scalar_s3 >= -SCALAR_WIDTH'(DOT_LIM))
		else $error("dot product outside clamp range");
`endif

endmodule

// ===== sv/quaternion_arithmetic_unit.sv =====
// top level of the quaternion arithmetic unit: front end, queue and execution pipeline
// Takes one request per cycle and returns one result per cycle while res_ready is high.
// A request is written into the two-entry queue, then passes three pipeline stages
// (operand select, sixteen parallel 17x17 rounded multipliers, sums and saturation into
// the output register) before its result is offered.
// A stalled output holds the whole pipeline; the queue keeps taking requests until full.
// Scalar operations give zero components and no flag; quaternion operations give scalar 0;
// opcode 7 gives an all-zero result.
module quaternion_arithmetic_unit import qau_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [2:0]                     req_type,
	input  comp_t                          a_i,
	input  comp_t                          a_j,
	input  comp_t                          a_k,
	input  comp_t                          a_w,
	input  comp_t                          b_i,
	input  comp_t                          b_j,
	input  comp_t                          b_k,
	input  comp_t                          b_w,
	input  comp_t                          factor,
	output logic                           res_valid,
	input  logic                           res_ready,
	output comp_t                          r_i,
	output comp_t                          r_j,
	output comp_t                          r_k,
	output comp_t                          r_w,
	output logic signed [SCALAR_WIDTH-1:0] scalar,
	output logic                           saturated
);

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_valid;
	item_t wr_item;
	item_t rd_item;

	qau_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.a_i       (a_i),
		.a_j       (a_j),
		.a_k       (a_k),
		.a_w       (a_w),
		.b_i       (b_i),
		.b_j       (b_j),
		.b_k       (b_k),
		.b_w       (b_w),
		.factor    (factor),
		.q_full    (q_full),
		.push      (push),
		.item      (wr_item)
	);

	qau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.full    (q_full),
		.q_valid (q_valid),
		.rd_item (rd_item)
	);

	qau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (rd_item),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.r_i       (r_i),
		.r_j       (r_j),
		.r_k       (r_k),
		.r_w       (r_w),
		.scalar    (scalar),
		.saturated (saturated)
	);

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the quaternion arithmetic unit, with its scoreboard class
`timescale 1ns / 1ps

import qau_pkg::*;

typedef struct packed {
	logic [2:0] op;
	quat_t      a;
	quat_t      b;
	comp_t      t;
} qreq_t;

typedef struct packed {
	logic [2:0]                     op;
	quat_t                          r;
	logic signed [SCALAR_WIDTH-1:0] sc;
	logic                           sat;
} qres_t;

function automatic quat_t pack_quat(comp_t i, comp_t j, comp_t k, comp_t w);
	quat_t q;
	q[QI] = i;
	q[QJ] = j;
	q[QK] = k;
	q[QW] = w;
	return q;
endfunction

class qau_scoreboard;
	qres_t awaited_results[$];
	int    errors;

	function new();
		errors = 0;
	endfunction

	function int pending();
		return awaited_results.size();
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// product of two Q1.14 values, rounded to nearest with half an lsb
	function longint rnd_mul(longint x, longint y);
		return (x * y + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function longint clip(longint v, int w, inout bit hit);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			hit = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function qres_t quat_alu_result(qreq_t rq);
		qres_t  res;
		longint a [NUM_COMP];
		longint b [NUM_COMP];
		longint r [NUM_COMP];
		longint t;
		longint s;
		longint lim;
		bit     hit;
		bit     unused;
		int     n;
		hit    = 1'b0;
		unused = 1'b0;
		s      = 0;
		lim    = (longint'(1) <<< FRAC_BITS) - 1;
		t      = longint'(comp_t'(rq.t));
		for (n = 0; n < NUM_COMP; n++) begin
			a[n] = longint'(comp_t'(rq.a[n]));
			b[n] = longint'(comp_t'(rq.b[n]));
			r[n] = 0;
		end
		case (op_t'(rq.op))
			OP_ADD: begin
				for (n = 0; n < NUM_COMP; n++)
					r[n] = a[n] + b[n];
			end
			OP_MUL: begin
				r[QI] = rnd_mul(a[QJ], b[QK]) - rnd_mul(a[QK], b[QJ])
					+ rnd_mul(a[QW], b[QI]) + rnd_mul(a[QI], b[QW]);
				r[QJ] = rnd_mul(a[QK], b[QI]) - rnd_mul(a[QI], b[QK])
					+ rnd_mul(a[QW], b[QJ]) + rnd_mul(a[QJ], b[QW]);
				r[QK] = rnd_mul(a[QI], b[QJ]) - rnd_mul(a[QJ], b[QI])
					+ rnd_mul(a[QW], b[QK]) + rnd_mul(a[QK], b[QW]);
				r[QW] = rnd_mul(a[QW], b[QW]) - rnd_mul(a[QI], b[QI])
					- rnd_mul(a[QJ], b[QJ]) - rnd_mul(a[QK], b[QK]);
			end
			OP_CONJ: begin
				r[QI] = -a[QI];
				r[QJ] = -a[QJ];
				r[QK] = -a[QK];
				r[QW] = a[QW];
			end
			OP_SCALE: begin
				for (n = 0; n < NUM_COMP; n++)
					r[n] = rnd_mul(t, a[n]);
			end
			OP_LERP: begin
				for (n = 0; n < NUM_COMP; n++)
					r[n] = a[n] + rnd_mul(t, b[n] - a[n]);
			end
			OP_NORM: begin
				for (n = 0; n < NUM_COMP; n++)
					s += rnd_mul(a[n], a[n]);
			end
			OP_DOT: begin
				for (n = 0; n < NUM_COMP; n++)
					s += rnd_mul(a[n], b[n]);
				// clamp just inside one, without the flag
				if (s > lim)
					s = lim;
				else if (s < -lim)
					s = -lim;
			end
			// unused opcode leaves components, scalar and flag at zero
			default: ;
		endcase
		res.op = rq.op;
		for (n = 0; n < NUM_COMP; n++)
			res.r[n] = comp_t'(clip(r[n], COMP_WIDTH, hit));
		res.sc  = SCALAR_WIDTH'(clip(s, SCALAR_WIDTH, unused));
		res.sat = hit;
		return res;
	endfunction

	function void note_request(qreq_t rq);
		awaited_results.push_back(quat_alu_result(rq));
	endfunction

	task check_result(qres_t got);
		qres_t want;
		int    n;
		if (awaited_results.size() == 0) begin
			report("result with no request outstanding");
			return;
		end
		want = awaited_results.pop_front();
		for (n = 0; n < NUM_COMP; n++) begin
			if (got.r[n] !== want.r[n])
				report($sformatf("op %0d component %0d: got %0d, expected %0d", want.op, n,
					$signed(got.r[n]), $signed(want.r[n])));
		end
		if (got.sc !== want.sc)
			report($sformatf("op %0d scalar: got %0d, expected %0d", want.op,
				$signed(got.sc), $signed(want.sc)));
		if (got.sat !== want.sat)
			report($sformatf("op %0d saturated: got %b, expected %b", want.op,
				got.sat, want.sat));
	endtask
endclass

module testbench;

	localparam comp_t CMAX        = comp_t'(16'h7fff);
	localparam comp_t CMIN        = comp_t'(16'h8000);
	localparam comp_t ONE         = comp_t'(1 << FRAC_BITS);
	localparam comp_t HALF        = comp_t'(1 << (FRAC_BITS - 1));
	localparam int    RANDOM_REQS = 1300;
	localparam int    HOLD_CYCLES = 120;
	localparam int    DRAIN_WAIT  = 16;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_ready;
	logic [2:0]                     req_type;
	comp_t                          a_i, a_j, a_k, a_w;
	comp_t                          b_i, b_j, b_k, b_w;
	comp_t                          factor;
	logic                           res_valid;
	logic                           res_ready;
	comp_t                          r_i, r_j, r_k, r_w;
	logic signed [SCALAR_WIDTH-1:0] scalar;
	logic                           saturated;

	qau_scoreboard sb;
	int            accepted_reqs = 0;

	quaternion_arithmetic_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.a_i       (a_i),
		.a_j       (a_j),
		.a_k       (a_k),
		.a_w       (a_w),
		.b_i       (b_i),
		.b_j       (b_j),
		.b_k       (b_k),
		.b_w       (b_w),
		.factor    (factor),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.r_i       (r_i),
		.r_j       (r_j),
		.r_k       (r_k),
		.r_w       (r_w),
		.scalar    (scalar),
		.saturated (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic qreq_t make_req(op_t op, quat_t a, quat_t b, comp_t t);
		qreq_t rq;
		rq.op = op;
		rq.a  = a;
		rq.b  = b;
		rq.t  = t;
		return rq;
	endfunction

	// extremes, values from minus one to one and tiny values for the rounding, otherwise anything
	function automatic comp_t rand_comp();
		case ($urandom_range(0, 9))
			0:       return CMAX;
			1:       return CMIN;
			2, 3:    return comp_t'($urandom_range(0, 2 * ONE) - ONE);
			4:       return comp_t'($urandom_range(0, 8) - 4);
			default: return comp_t'($urandom);
		endcase
	endfunction

	function automatic quat_t rand_quat();
		return pack_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
	endfunction

	task automatic send_req(qreq_t rq);
		@(negedge clk);
		req_valid <= 1'b1;
		req_type  <= rq.op;
		a_i       <= rq.a[QI];
		a_j       <= rq.a[QJ];
		a_k       <= rq.a[QK];
		a_w       <= rq.a[QW];
		b_i       <= rq.b[QI];
		b_j       <= rq.b[QJ];
		b_k       <= rq.b[QK];
		b_w       <= rq.b[QW];
		factor    <= rq.t;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic pause_req(int cycles);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				sb.note_request(make_req(op_t'(req_type), pack_quat(a_i, a_j, a_k, a_w),
					pack_quat(b_i, b_j, b_k, b_w), factor));
				accepted_reqs++;
			end
			if (res_valid && res_ready)
				sb.check_result('{op: 3'd0, r: pack_quat(r_i, r_j, r_k, r_w),
					sc: scalar, sat: saturated});
		end
	end

	// result sink: stretches of differing stall patterns, and two long hold-offs
	initial begin
		int len;
		int style;
		int holds;
		res_ready = 1'b0;
		holds     = 0;
		wait (arst_n === 1'b1);
		forever begin
			if ((holds == 0 && accepted_reqs >= 60) || (holds == 1 && accepted_reqs >= 700)) begin
				holds++;
				repeat (HOLD_CYCLES) @(negedge clk) res_ready <= 1'b0;
			end
			len   = $urandom_range(10, 60);
			style = $urandom_range(0, 3);
			repeat (len) begin
				@(negedge clk);
				case (style)
					0:       res_ready <= 1'b1;
					1:       res_ready <= ($urandom_range(0, 3) != 0);
					2:       res_ready <= ~res_ready;
					default: res_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		qreq_t directed[$];
		qreq_t rq;
		quat_t qmax;
		quat_t qmin;
		quat_t qzero;
		int    sent;
		int    burst;
		sb        = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_type  = 3'd0;
		{a_i, a_j, a_k, a_w} = '0;
		{b_i, b_j, b_k, b_w} = '0;
		factor    = '0;
		qmax  = pack_quat(CMAX, CMAX, CMAX, CMAX);
		qmin  = pack_quat(CMIN, CMIN, CMIN, CMIN);
		qzero = pack_quat(0, 0, 0, 0);

		directed.push_back(make_req(OP_ADD, qmax, qmax, 0));
		directed.push_back(make_req(OP_ADD, qmin, qmin, 0));
		directed.push_back(make_req(OP_ADD, pack_quat(100, -200, CMAX, CMIN),
			pack_quat(-100, 50, CMIN, CMAX), 0));
		directed.push_back(make_req(OP_MUL, pack_quat(1234, -5678, 910, ONE),
			pack_quat(0, 0, 0, ONE), 0));
		directed.push_back(make_req(OP_MUL, qmin, qmin, 0));
		directed.push_back(make_req(OP_MUL, qmax, qmin, 0));
		directed.push_back(make_req(OP_MUL, qmax, qmax, 0));
		// negating the most negative value clips
		directed.push_back(make_req(OP_CONJ, qmin, qzero, 0));
		directed.push_back(make_req(OP_CONJ, pack_quat(ONE, -HALF, 7, CMAX), qzero, 0));
		// exact half-lsb ties round upwards for both signs
		directed.push_back(make_req(OP_SCALE, pack_quat(1, -1, 3, -3), qzero, HALF));
		directed.push_back(make_req(OP_SCALE, qmin, qzero, CMIN));
		directed.push_back(make_req(OP_SCALE, qmax, qzero, CMAX));
		directed.push_back(make_req(OP_LERP, pack_quat(100, -100, 5, 9),
			pack_quat(-3000, 3000, ONE, -ONE), 0));
		directed.push_back(make_req(OP_LERP, pack_quat(100, -100, 5, 9),
			pack_quat(-3000, 3000, ONE, -ONE), ONE));
		directed.push_back(make_req(OP_LERP, qmin, qmax, CMAX));
		directed.push_back(make_req(OP_LERP, qmax, qmin, CMAX));
		directed.push_back(make_req(OP_NORM, qmin, qzero, 0));
		directed.push_back(make_req(OP_NORM, qzero, qmax, CMAX));
		directed.push_back(make_req(OP_DOT, qmax, qmax, 0));
		directed.push_back(make_req(OP_DOT, qmax, qmin, 0));
		directed.push_back(make_req(OP_DOT, pack_quat(HALF, 0, 0, HALF),
			pack_quat(HALF, 0, 0, -ONE), 0));
		directed.push_back(make_req(OP_NONE, qmax, qmin, CMIN));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part back to back, no gaps on the sender side
		foreach (directed[n])
			send_req(directed[n]);

		sent = 0;
		while (sent < RANDOM_REQS) begin
			burst = $urandom_range(1, 40);
			for (int n = 0; n < burst && sent < RANDOM_REQS; n++) begin
				rq = make_req(op_t'($urandom_range(0, 7)), rand_quat(), rand_quat(),
					rand_comp());
				send_req(rq);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_req($urandom_range(1, 8));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
